[hw/rtl/wfp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wfp_pkg: shared types and constants for the wall-follow PID steering core
// Register map, reset values, lane and selection records, and the fixed-point
// widths used by the PID datapath.
// ----------------------------------------------------------------------------
package wfp_pkg;

	// Sensor readings and setpoints, unsigned millimetres
	typedef logic [15:0] range_t;
	// Setpoint minus reading, -65535..65535
	typedef logic signed [16:0] err_t;
	// Integral, error and error difference as carried by the PID state
	typedef logic signed [17:0] state_t;
	// Nearest sensor code
	typedef logic [1:0] sensor_t;

	localparam sensor_t SENSOR_FIVE  = 2'd0;
	localparam sensor_t SENSOR_SIX   = 2'd1;
	localparam sensor_t SENSOR_SEVEN = 2'd2;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_GAIN_PROP      = 3'd0,
		REG_GAIN_INTEG     = 3'd1,
		REG_GAIN_DERIV     = 3'd2,
		REG_SETPOINT_FIVE  = 3'd3,
		REG_SETPOINT_SIX   = 3'd4,
		REG_SETPOINT_SEVEN = 3'd5,
		REG_FAR_LIMIT      = 3'd6,
		REG_BASE_SPEED     = 3'd7
	} reg_idx_t;

	localparam int unsigned CFG_DATA_W = 32;

	typedef struct packed {
		logic [31:0]        gain_prop;
		logic [31:0]        gain_integ;
		logic [31:0]        gain_deriv;
		range_t             setpoint_five;
		range_t             setpoint_six;
		range_t             setpoint_seven;
		range_t             far_limit;
		logic signed [15:0] base_speed;
	} cfg_t;

	localparam logic [31:0]        RST_GAIN_PROP      = 32'd2181038;
	localparam logic [31:0]        RST_GAIN_INTEG     = 32'd1;
	localparam logic [31:0]        RST_GAIN_DERIV     = 32'd0;
	localparam range_t             RST_SETPOINT_FIVE  = 16'd1080;
	localparam range_t             RST_SETPOINT_SIX   = 16'd650;
	localparam range_t             RST_SETPOINT_SEVEN = 16'd475;
	localparam range_t             RST_FAR_LIMIT      = 16'd5000;
	localparam logic signed [15:0] RST_BASE_SPEED     = 16'sd100;

	// One lane's view of its sensor
	typedef struct packed {
		range_t reading;
		err_t   err;
	} lane_t;

	// What the merge stage found
	typedef struct packed {
		sensor_t idx;
		err_t    err;
		logic    far;
	} pick_t;

	// Integral clamp window
	localparam state_t INTEG_HI = 18'sd2000;
	localparam state_t INTEG_LO = -18'sd2000;

	// Fixed-point datapath widths (Q.24 fraction)
	localparam int unsigned FRAC_W = 24;
	localparam int unsigned PROD_W = 51;   // 33-bit signed gain x 18-bit signed
	localparam int unsigned TERM_W = 53;   // sum of three products
	localparam int unsigned ACC_W  = 54;   // base plus or minus term

	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	// Term used when the nearest wall is out of range: 2.0 in Q.24
	localparam term_t FAR_TERM = term_t'(2) <<< FRAC_W;

endpackage : wfp_pkg
`default_nettype wire

[hw/rtl/wfp_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wfp_cfg_regs: configuration register file
// Eight write-only registers loaded from the configuration channel; data is
// masked to each register's width.
// ----------------------------------------------------------------------------
module wfp_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [2:0]                      cfg_index,
	input  wire logic [wfp_pkg::CFG_DATA_W-1:0]  cfg_data,
	output wfp_pkg::cfg_t                        cfg
);
	import wfp_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop      <= RST_GAIN_PROP;
			cfg_q.gain_integ     <= RST_GAIN_INTEG;
			cfg_q.gain_deriv     <= RST_GAIN_DERIV;
			cfg_q.setpoint_five  <= RST_SETPOINT_FIVE;
			cfg_q.setpoint_six   <= RST_SETPOINT_SIX;
			cfg_q.setpoint_seven <= RST_SETPOINT_SEVEN;
			cfg_q.far_limit      <= RST_FAR_LIMIT;
			cfg_q.base_speed     <= RST_BASE_SPEED;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_GAIN_PROP:      cfg_q.gain_prop      <= cfg_data;
				REG_GAIN_INTEG:     cfg_q.gain_integ     <= cfg_data;
				REG_GAIN_DERIV:     cfg_q.gain_deriv     <= cfg_data;
				REG_SETPOINT_FIVE:  cfg_q.setpoint_five  <= cfg_data[15:0];
				REG_SETPOINT_SIX:   cfg_q.setpoint_six   <= cfg_data[15:0];
				REG_SETPOINT_SEVEN: cfg_q.setpoint_seven <= cfg_data[15:0];
				REG_FAR_LIMIT:      cfg_q.far_limit      <= cfg_data[15:0];
				REG_BASE_SPEED:     cfg_q.base_speed     <= $signed(cfg_data[15:0]);
				default: ;
			endcase
		end
	end

endmodule : wfp_cfg_regs
`default_nettype wire

[hw/rtl/wfp_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wfp_lane: per-sensor error lane
// Forms setpoint minus reading for one sensor and passes the reading on.
// ----------------------------------------------------------------------------
module wfp_lane (
	input  wire wfp_pkg::range_t reading,
	input  wire wfp_pkg::range_t setpoint,
	output wfp_pkg::lane_t       lane
);
	import wfp_pkg::*;

	err_t err;

	assign err          = $signed({1'b0, setpoint}) - $signed({1'b0, reading});
	assign lane.reading = reading;
	assign lane.err     = err;

endmodule : wfp_lane
`default_nettype wire

[hw/rtl/wfp_merge.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wfp_merge: nearest-sensor merge
// Picks the lane with the smallest reading (earlier sensor on a tie) and
// flags a reading at or beyond the far limit.
// ----------------------------------------------------------------------------
module wfp_merge (
	input  wire wfp_pkg::lane_t  lane_five,
	input  wire wfp_pkg::lane_t  lane_six,
	input  wire wfp_pkg::lane_t  lane_seven,
	input  wire wfp_pkg::range_t far_limit,
	output wfp_pkg::pick_t       pick
);
	import wfp_pkg::*;

	logic   six_lt_five;
	logic   seven_lt_five;
	logic   seven_lt_six;
	lane_t  best;

	// All three compares side by side, then resolve
	assign six_lt_five   = lane_six.reading   < lane_five.reading;
	assign seven_lt_five = lane_seven.reading < lane_five.reading;
	assign seven_lt_six  = lane_seven.reading < lane_six.reading;

	always_comb begin
		if (six_lt_five ? seven_lt_six : seven_lt_five) begin
			pick.idx = SENSOR_SEVEN;
			best     = lane_seven;
		end else if (six_lt_five) begin
			pick.idx = SENSOR_SIX;
			best     = lane_six;
		end else begin
			pick.idx = SENSOR_FIVE;
			best     = lane_five;
		end
		pick.err = best.err;
		pick.far = best.reading >= far_limit;
	end

endmodule : wfp_merge
`default_nettype wire

[hw/rtl/wall_follow_pid_steering_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wall_follow_pid_steering_core: wall-following PID steering
// Pipeline: an accepted sample passes every registered stage to the output.
// Throughput: one sample per cycle unless result_stall backs up; the integral
//   and prev-error update closes in stage one; back-to-back samples never wait.
// Reset: arst_n clears the pipeline, the integral and the previous error, and
//   loads the default gains, setpoints, far limit and base speed.
// ----------------------------------------------------------------------------
module wall_follow_pid_steering_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [2:0]                      cfg_index,
	input  wire logic [wfp_pkg::CFG_DATA_W-1:0]  cfg_data,
	// sample channel
	input  wire logic                            sample_valid,
	output logic                                 sample_stall,
	input  wire wfp_pkg::range_t                 range_five,
	input  wire wfp_pkg::range_t                 range_six,
	input  wire wfp_pkg::range_t                 range_seven,
	// result channel
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output logic signed [15:0]                   left_speed,
	output logic signed [15:0]                   right_speed,
	output wfp_pkg::sensor_t                     nearest_sensor,
	output logic                                 far_flag
);
	import wfp_pkg::*;

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------
	cfg_t cfg;

	wfp_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// ------------------------------------------------------------------
	// Lanes: one error unit per sensor, then merge to the nearest one
	// ------------------------------------------------------------------
	lane_t lane_five;
	lane_t lane_six;
	lane_t lane_seven;
	pick_t pick;

	wfp_lane u_lane_five (
		.reading  (range_five),
		.setpoint (cfg.setpoint_five),
		.lane     (lane_five)
	);

	wfp_lane u_lane_six (
		.reading  (range_six),
		.setpoint (cfg.setpoint_six),
		.lane     (lane_six)
	);

	wfp_lane u_lane_seven (
		.reading  (range_seven),
		.setpoint (cfg.setpoint_seven),
		.lane     (lane_seven)
	);

	wfp_merge u_merge (
		.lane_five  (lane_five),
		.lane_six   (lane_six),
		.lane_seven (lane_seven),
		.far_limit  (cfg.far_limit),
		.pick       (pick)
	);

	// ------------------------------------------------------------------
	// Pipeline flow control
	// Each stage advances when it is empty or the next stage advances, so
	// bubbles collapse and a held result never blocks the stages behind it
	// until the pipe is full.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic accept;

	assign en_s5 = !v_s5 || !result_stall;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign sample_stall = !en_s1;
	assign accept       = sample_valid && en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= sample_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// ------------------------------------------------------------------
	// PID state: integral with clamp window, previous error
	// Updated on every accepted transaction, including far readings.
	// ------------------------------------------------------------------
	state_t integ_q;
	state_t prev_err_q;
	state_t err_ext;
	state_t integ_nxt;
	state_t derr;
	logic   integ_in_band;

	assign err_ext       = {pick.err[16], pick.err};
	assign integ_in_band = (integ_q >= INTEG_LO) && (integ_q <= INTEG_HI);
	assign derr          = err_ext - prev_err_q;

	always_comb begin
		if (integ_in_band) begin
			// add the error; may overshoot the window by up to one error's worth
			integ_nxt = integ_q + err_ext;
		end else if (integ_q < INTEG_LO) begin
			integ_nxt = INTEG_LO;
		end else begin
			integ_nxt = INTEG_HI;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			prev_err_q <= '0;
		end else if (accept) begin
			integ_q    <= integ_nxt;
			prev_err_q <= err_ext;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: error, updated integral and error difference
	// ------------------------------------------------------------------
	state_t  err_s1;
	state_t  integ_s1;
	state_t  derr_s1;
	logic    far_s1;
	sensor_t idx_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			err_s1   <= err_ext;
			integ_s1 <= integ_nxt;
			derr_s1  <= derr;
			far_s1   <= pick.far;
			idx_s1   <= pick.idx;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: three gain multiplies in parallel (33 x 18 signed)
	// ------------------------------------------------------------------
	logic signed [32:0] gain_p;
	logic signed [32:0] gain_i;
	logic signed [32:0] gain_d;
	prod_t   p_prop_s2;
	prod_t   p_integ_s2;
	prod_t   p_deriv_s2;
	logic    far_s2;
	sensor_t idx_s2;

	assign gain_p = $signed({1'b0, cfg.gain_prop});
	assign gain_i = $signed({1'b0, cfg.gain_integ});
	assign gain_d = $signed({1'b0, cfg.gain_deriv});

	always_ff @(posedge clk) begin
		if (en_s2) begin
			p_prop_s2  <= gain_p * err_s1;
			p_integ_s2 <= gain_i * integ_s1;
			p_deriv_s2 <= gain_d * derr_s1;
			far_s2     <= far_s1;
			idx_s2     <= idx_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: PID sum, replaced by 2.0 on a far reading
	// ------------------------------------------------------------------
	term_t   term_sum;
	term_t   term_s3;
	logic    far_s3;
	sensor_t idx_s3;

	assign term_sum = {{(TERM_W-PROD_W){p_prop_s2[PROD_W-1]}},  p_prop_s2}
	                + {{(TERM_W-PROD_W){p_integ_s2[PROD_W-1]}}, p_integ_s2}
	                + {{(TERM_W-PROD_W){p_deriv_s2[PROD_W-1]}}, p_deriv_s2};

	always_ff @(posedge clk) begin
		if (en_s3) begin
			term_s3 <= far_s2 ? FAR_TERM : term_sum;
			far_s3  <= far_s2;
			idx_s3  <= idx_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: base speed minus / plus the term, exact in Q.24
	// ------------------------------------------------------------------
	acc_t    base_q;
	acc_t    term_ext;
	acc_t    left_q_s4;
	acc_t    right_q_s4;
	logic    far_s4;
	sensor_t idx_s4;

	assign base_q   = {{(ACC_W-16-FRAC_W){cfg.base_speed[15]}}, cfg.base_speed,
	                   {FRAC_W{1'b0}}};
	assign term_ext = {{(ACC_W-TERM_W){term_s3[TERM_W-1]}}, term_s3};

	always_ff @(posedge clk) begin
		if (en_s4) begin
			left_q_s4  <= base_q - term_ext;
			right_q_s4 <= base_q + term_ext;
			far_s4     <= far_s3;
			idx_s4     <= idx_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: truncate toward zero and saturate to 16 bits
	// ------------------------------------------------------------------
	localparam int unsigned INT_W = ACC_W - FRAC_W;

	function automatic logic signed [15:0] wheel_sat(input acc_t q);
		logic signed [INT_W-1:0] floor_v;
		logic signed [INT_W-1:0] trunc_v;
		logic                    round_up;
		floor_v  = q[ACC_W-1:FRAC_W];
		// floor differs from truncation only for negative values with a fraction
		round_up = q[ACC_W-1] && (|q[FRAC_W-1:0]);
		trunc_v  = floor_v + {{(INT_W-1){1'b0}}, round_up};
		if (trunc_v > $signed(INT_W'(32767))) begin
			wheel_sat = 16'sh7fff;
		end else if (trunc_v < -$signed(INT_W'(32768))) begin
			wheel_sat = 16'sh8000;
		end else begin
			wheel_sat = trunc_v[15:0];
		end
	endfunction

	logic signed [15:0] left_s5;
	logic signed [15:0] right_s5;
	logic               far_s5;
	sensor_t            idx_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			left_s5  <= wheel_sat(left_q_s4);
			right_s5 <= wheel_sat(right_q_s4);
			far_s5   <= far_s4;
			idx_s5   <= idx_s4;
		end
	end

	// Output register: hold while the result transaction is stalled
	assign result_valid   = v_s5;
	assign left_speed     = left_s5;
	assign right_speed    = right_s5;
	assign nearest_sensor = idx_s5;
	assign far_flag       = far_s5;

endmodule : wall_follow_pid_steering_core
`default_nettype wire

[tb/wall_follow_pid_steering_core_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wall_follow_pid_steering_core_tb: self-checking bench for the steering core
// Sweeps of three range readings go in, one steering result per sweep comes
// out. A behavioral predictor tracks the integral and previous error, forms
// the exact Q.24 PID term and the saturated wheel speeds, and every result is
// compared field by field in order. Phases change the register set (defaults,
// random, both extremes) and the idle pattern on both sides.
// ----------------------------------------------------------------------------
module wall_follow_pid_steering_core_tb;
	import wfp_pkg::*;

	localparam int    CLK_PERIOD     = 12;
	localparam int    RESET_CYCLES   = 12;
	localparam int    TAIL_CYCLES    = 20;
	localparam int    TIMEOUT_CYCLES = 400000;
	localparam int    SWEEPS_PER_RUN = 170;
	localparam longint Q_ONE         = longint'(1) <<< FRAC_W;

	// One sonar sweep as handed to the core
	typedef struct packed {
		range_t rng_five;
		range_t rng_six;
		range_t rng_seven;
	} sweep_t;

	// One steering result
	typedef struct packed {
		logic signed [15:0] left_spd;
		logic signed [15:0] right_spd;
		sensor_t            sensor;
		logic               far;
	} steer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic        sample_valid = 1'b0;
	logic        sample_stall;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic signed [15:0] left_speed;
	logic signed [15:0] right_speed;
	sensor_t     nearest_sensor;
	logic        far_flag;

	sweep_t      cur_sweep = '0;
	logic        sweep_taken = 1'b0;

	sweep_t      pending_sweeps[$];
	steer_t      steer_expect[$];

	int          send_idle_pct = 0;
	int          hold_pct = 0;
	int          mismatches = 0;

	// Shadow of the register file
	logic [31:0]        gain_p, gain_i, gain_d;
	range_t             sp_cfg[3];
	range_t             far_cfg;
	logic signed [15:0] base_cfg;

	// Controller state as the core should carry it
	int integ_sum;
	int last_err;

	wire range_t range_five;
	wire range_t range_six;
	wire range_t range_seven;

	assign range_five  = cur_sweep.rng_five;
	assign range_six   = cur_sweep.rng_six;
	assign range_seven = cur_sweep.rng_seven;

	wall_follow_pid_steering_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.range_five     (range_five),
		.range_six      (range_six),
		.range_seven    (range_seven),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.left_speed     (left_speed),
		.right_speed    (right_speed),
		.nearest_sensor (nearest_sensor),
		.far_flag       (far_flag)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Truncate a Q.24 speed toward zero and saturate it to 16 bits
	function automatic logic signed [15:0] wheel_speed(input longint q);
		longint v;
		v = q / Q_ONE;
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	// Advance the controller state by one sweep and return the steering it yields
	function automatic steer_t steer_from_sweep(input sweep_t s);
		range_t rd[3];
		int     k;
		int     spv, rdv, err, derr;
		longint gp, gi, gd, term, base_q;
		steer_t res;
		rd[0] = s.rng_five;
		rd[1] = s.rng_six;
		rd[2] = s.rng_seven;
		// strict compare: on a tie the earlier sensor keeps the pick
		k = 0;
		for (int i = 1; i < 3; i++)
			if (rd[i] < rd[k])
				k = i;
		spv = sp_cfg[k];
		rdv = rd[k];
		err = spv - rdv;
		// add while inside the window, otherwise snap to the bound
		if (integ_sum >= int'(INTEG_LO) && integ_sum <= int'(INTEG_HI))
			integ_sum += err;
		else if (integ_sum < int'(INTEG_LO))
			integ_sum = int'(INTEG_LO);
		else
			integ_sum = int'(INTEG_HI);
		derr = err - last_err;
		last_err = err;
		gp = gain_p;
		gi = gain_i;
		gd = gain_d;
		term = gp * err + gi * integ_sum + gd * derr;
		res.far = (rd[k] >= far_cfg);
		if (res.far)
			term = 2 * Q_ONE;
		base_q = longint'(base_cfg) * Q_ONE;
		res.left_spd  = wheel_speed(base_q - term);
		res.right_spd = wheel_speed(base_q + term);
		res.sensor    = sensor_t'(k);
		return res;
	endfunction

	// Sender: hold the payload while stalled, advance once the transaction is taken
	always @(negedge clk) begin : drive_sweeps
		if (arst_n && (!sample_valid || sweep_taken)) begin
			sweep_taken = 1'b0;
			if (pending_sweeps.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_sweep = pending_sweeps.pop_front();
				sample_valid <= 1'b1;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall at the phase's rate
	always @(negedge clk) begin : drive_stall
		result_stall <= ($urandom_range(99) < hold_pct);
	end

	// Predict on every accepted sweep, then check every accepted result
	always @(posedge clk) begin : track_steering
		steer_t want, got;
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				steer_expect.push_back(steer_from_sweep(cur_sweep));
				sweep_taken = 1'b1;
			end
			if (result_valid && !result_stall) begin
				got = '{left_speed, right_speed, nearest_sensor, far_flag};
				if (steer_expect.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result left %0d right %0d sensor %0d far %0b",
						$time, got.left_spd, got.right_spd, got.sensor, got.far);
				end else begin
					want = steer_expect.pop_front();
					if (got.left_spd !== want.left_spd) begin
						mismatches++;
						$display("%0t: left_speed expected %0d actual %0d",
							$time, want.left_spd, got.left_spd);
					end
					if (got.right_spd !== want.right_spd) begin
						mismatches++;
						$display("%0t: right_speed expected %0d actual %0d",
							$time, want.right_spd, got.right_spd);
					end
					if (got.sensor !== want.sensor) begin
						mismatches++;
						$display("%0t: nearest_sensor expected %0d actual %0d",
							$time, want.sensor, got.sensor);
					end
					if (got.far !== want.far) begin
						mismatches++;
						$display("%0t: far_flag expected %0b actual %0b",
							$time, want.far, got.far);
					end
				end
			end
		end
	end

	// Start a register write at a falling edge; return at the next falling edge
	// with valid still high so back-to-back writes need no toggle
	task automatic cfg_write(input reg_idx_t idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_GAIN_PROP:      gain_p = data;
			REG_GAIN_INTEG:     gain_i = data;
			REG_GAIN_DERIV:     gain_d = data;
			REG_SETPOINT_FIVE:  sp_cfg[0] = data[15:0];
			REG_SETPOINT_SIX:   sp_cfg[1] = data[15:0];
			REG_SETPOINT_SEVEN: sp_cfg[2] = data[15:0];
			REG_FAR_LIMIT:      far_cfg = data[15:0];
			REG_BASE_SPEED:     base_cfg = data[15:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Write the whole register file; upper data bits are junk on purpose to
	// exercise masking of the 16-bit registers
	task automatic program_regs(input logic [31:0] gp, input logic [31:0] gi,
			input logic [31:0] gd, input range_t s5, input range_t s6, input range_t s7,
			input range_t far, input logic [15:0] base);
		cfg_write(REG_GAIN_PROP, gp);
		cfg_write(REG_GAIN_INTEG, gi);
		cfg_write(REG_GAIN_DERIV, gd);
		cfg_write(REG_SETPOINT_FIVE, {16'($urandom_range(65535)), s5});
		cfg_write(REG_SETPOINT_SIX, {16'($urandom_range(65535)), s6});
		cfg_write(REG_SETPOINT_SEVEN, {16'($urandom_range(65535)), s7});
		cfg_write(REG_FAR_LIMIT, {16'($urandom_range(65535)), far});
		cfg_write(REG_BASE_SPEED, {16'($urandom_range(65535)), base});
		cfg_valid <= 1'b0;
	endtask

	// Hold until every queued sweep is taken and every result has come back,
	// then return at a falling edge
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_sweeps.size() != 0 || sample_valid || steer_expect.size() != 0);
		@(negedge clk);
	endtask

	function automatic range_t clamp_range(input int v);
		if (v < 0)
			return '0;
		if (v > 65535)
			return '1;
		return v[15:0];
	endfunction

	function automatic sweep_t mk_sweep(input int a, input int b, input int c);
		return '{a[15:0], b[15:0], c[15:0]};
	endfunction

	// Mostly plausible wall geometry around the active setpoints, the rest
	// raw noise, far-limit edges and rail values
	task automatic queue_random_sweeps(input int n);
		int     mode, k, v, offs, spread;
		range_t rd[3];
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(99);
			if (mode < 60) begin
				k = $urandom_range(2);
				offs = $urandom_range(800);
				v = int'(sp_cfg[k]) + offs - 400;
				rd[k] = clamp_range(v);
				for (int j = 0; j < 3; j++) begin
					if (j != k) begin
						spread = $urandom_range(3000);
						rd[j] = ($urandom_range(9) == 0) ? rd[k] :
							clamp_range(int'(rd[k]) + 1 + spread);
					end
				end
			end else if (mode < 80) begin
				for (int j = 0; j < 3; j++)
					rd[j] = 16'($urandom_range(65535));
			end else if (mode < 90) begin
				for (int j = 0; j < 3; j++) begin
					offs = $urandom_range(6);
					rd[j] = clamp_range(int'(far_cfg) + offs - 3);
				end
			end else begin
				for (int j = 0; j < 3; j++) begin
					case ($urandom_range(3))
						0: rd[j] = 16'h0000;
						1: rd[j] = 16'h0001;
						2: rd[j] = 16'hfffe;
						default: rd[j] = 16'hffff;
					endcase
				end
			end
			pending_sweeps.push_back('{rd[0], rd[1], rd[2]});
		end
	endtask

	function automatic logic [31:0] rand_gain();
		return $urandom() >> $urandom_range(31);
	endfunction

	initial begin : stimulus
		// register shadow and state start from their reset values
		gain_p    = RST_GAIN_PROP;
		gain_i    = RST_GAIN_INTEG;
		gain_d    = RST_GAIN_DERIV;
		sp_cfg[0] = RST_SETPOINT_FIVE;
		sp_cfg[1] = RST_SETPOINT_SIX;
		sp_cfg[2] = RST_SETPOINT_SEVEN;
		far_cfg   = RST_FAR_LIMIT;
		base_cfg  = RST_BASE_SPEED;
		integ_sum = 0;
		last_err  = 0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Directed sweeps on the reset register set, no idling
		pending_sweeps.push_back(mk_sweep(0, 0, 0));              // three-way tie at zero
		pending_sweeps.push_back(mk_sweep(65535, 65535, 65535));  // top of range, far
		pending_sweeps.push_back(mk_sweep(1000, 2000, 3000));     // five nearest
		pending_sweeps.push_back(mk_sweep(2000, 600, 3000));      // six nearest
		pending_sweeps.push_back(mk_sweep(2000, 3000, 400));      // seven nearest
		pending_sweeps.push_back(mk_sweep(700, 700, 900));        // tie, five wins
		pending_sweeps.push_back(mk_sweep(900, 500, 500));        // tie, six wins
		pending_sweeps.push_back(mk_sweep(4999, 4999, 4999));     // one below far limit
		pending_sweeps.push_back(mk_sweep(5000, 6000, 7000));     // exactly at far limit
		// drive the integral up past the window, then let it clamp
		repeat (5) pending_sweeps.push_back(mk_sweep(0, 65535, 65535));
		// and down past the other bound
		repeat (4) pending_sweeps.push_back(mk_sweep(4000, 4900, 4950));
		pending_sweeps.push_back(mk_sweep(16'h5555, 16'haaaa, 16'hffff));
		pending_sweeps.push_back(mk_sweep(16'haaaa, 16'h5555, 16'h0001));
		wait_drained();

		// Random register set near the defaults, sender idles
		program_regs($urandom_range(1 << 26), $urandom_range(1 << 20),
			$urandom_range(1 << 24), 16'($urandom_range(400, 1500)),
			16'($urandom_range(400, 1500)), 16'($urandom_range(400, 1500)),
			16'($urandom_range(2000, 8000)), 16'($signed($urandom_range(1000)) - 500));
		send_idle_pct = 62;
		hold_pct = 0;
		queue_random_sweeps(SWEEPS_PER_RUN);
		wait_drained();

		// Every register at its top value, receiver stalls
		program_regs('1, '1, '1, '1, '1, '1, '1, 16'sh7fff);
		send_idle_pct = 0;
		hold_pct = 62;
		queue_random_sweeps(SWEEPS_PER_RUN);
		wait_drained();

		// Every register at its bottom value: always far, base at negative rail
		program_regs('0, '0, '0, '0, '0, '0, '0, 16'sh8000);
		send_idle_pct = 28;
		hold_pct = 28;
		queue_random_sweeps(SWEEPS_PER_RUN);
		wait_drained();

		// Wide random registers, no idling
		program_regs(rand_gain(), rand_gain(), rand_gain(), 16'($urandom_range(65535)),
			16'($urandom_range(65535)), 16'($urandom_range(65535)),
			16'($urandom_range(65535)), 16'($urandom_range(65535)));
		send_idle_pct = 0;
		hold_pct = 0;
		queue_random_sweeps(SWEEPS_PER_RUN);
		wait_drained();

		// Integral-heavy steering around the defaults, both sides idle
		program_regs($urandom_range(1 << 22), $urandom_range(1 << 26),
			$urandom_range(1 << 25), RST_SETPOINT_FIVE, RST_SETPOINT_SIX,
			RST_SETPOINT_SEVEN, RST_FAR_LIMIT, 16'sd0);
		send_idle_pct = 28;
		hold_pct = 28;
		queue_random_sweeps(SWEEPS_PER_RUN);
		wait_drained();

		// Let the pipeline settle so any stray result gets flagged
		hold_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("wall_follow_pid_steering_core_tb: clean");
		else
			$display("wall_follow_pid_steering_core_tb: errors");
		$finish;
	end

	initial begin : watchdog
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("wall_follow_pid_steering_core_tb: errors");
		$finish;
	end

endmodule : wall_follow_pid_steering_core_tb
`default_nettype wire
